// File: rtl/i2cbe_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2cbe_pkg: shared types and constants of the I2C master bit engine
// Command codes, register indexes, tick word layout and decoded word type.
// ----------------------------------------------------------------------------
package i2cbe_pkg;

    localparam int DATA_BITS  = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // command codes as carried in the operation field
    typedef enum logic [2:0] {
        OP_START = 3'd0,
        OP_STOP  = 3'd1,
        OP_WRITE = 3'd2,
        OP_READ  = 3'd3,
        OP_WAIT  = 3'd4
    } op_t;

    // register indexes on the configuration channel
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PHASE_TICKS = 2'd0,
        CFG_ACK_TIMEOUT = 2'd1
    } cfg_idx_t;

    // phase steps; the poll step only occurs for a wait for acknowledge
    localparam logic [1:0] STEP_0    = 2'd0;
    localparam logic [1:0] STEP_1    = 2'd1;
    localparam logic [1:0] STEP_2    = 2'd2;
    localparam logic [1:0] STEP_3    = 2'd3;
    localparam logic [1:0] STEP_POLL = 2'd2;

    // decoded tick word handed from the front to the back
    typedef struct packed {
        logic                 start;   // valid command with a known code
        op_t                  op;
        logic [DATA_BITS-1:0] tx_byte;
        logic                 send_ack;
        logic                 sda_in;
    } tick_t;

    typedef struct packed {
        logic [15:0] phase_ticks;
        logic [7:0]  ack_timeout;
    } cfg_t;

endpackage

`default_nettype wire

// File: rtl/i2cbe_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2cbe_front: tick word intake
// Decodes each incoming tick word and holds it in a two-entry queue.
// ----------------------------------------------------------------------------
module i2cbe_front
    import i2cbe_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       command_valid,
    input  wire logic [2:0] operation,
    input  wire logic [7:0] tx_byte,
    input  wire logic       send_ack,
    input  wire logic       sda_in,
    output logic            q_valid,
    input  wire logic       q_pop,
    output tick_t           q_word
);

    tick_t       mem [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        push, pop;
    tick_t       dec;

    // classify: unknown codes never start a command
    always_comb
    begin
        dec.start    = command_valid && (operation <= OP_WAIT);
        dec.op       = op_t'(operation);
        dec.tx_byte  = tx_byte;
        dec.send_ack = send_ack;
        dec.sda_in   = sda_in;
    end

    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign pop      = q_pop && (count_reg != 2'd0);
    assign q_valid  = (count_reg != 2'd0);
    assign q_word   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/i2cbe_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2cbe_back: line sequencer
// Steps the SCL/SDA phase machine once per tick word and holds the result.
// ----------------------------------------------------------------------------
module i2cbe_back
    import i2cbe_pkg::*;
#(
    parameter int PHASE_COUNT_WIDTH = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  cfg_t             cfg,
    input  wire logic        q_valid,
    output logic             q_pop,
    input  tick_t            q_word,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             scl_level,
    output logic             sda_level,
    output logic             sda_driving,
    output logic             busy_res,
    output logic             done_res,
    output logic [7:0]       rx_byte,
    output logic             ack_missing
);

    localparam int PCW = PHASE_COUNT_WIDTH;

    op_t                  cmd_reg, cmd_next;
    logic [DATA_BITS-1:0] shift_reg, shift_next;
    logic [3:0]           bit_reg, bit_next;
    logic [1:0]           step_reg, step_next;
    logic [PCW-1:0]       pcnt_reg, pcnt_next;
    logic [7:0]           ackw_reg, ackw_next;
    logic                 ack_choice_reg, ack_choice_next;
    logic                 busy_reg, busy_next;
    logic                 scl_reg, scl_next;
    logic                 sda_reg, sda_next;
    logic                 drive_reg, drive_next;
    logic [DATA_BITS-1:0] rx_reg, rx_next;
    logic                 err_reg, err_next;
    logic                 done_reg, done_next;
    logic                 valid_reg;

    logic                 take;
    logic [31:0]          ticks_wide;
    logic [PCW-1:0]       reload;
    logic [PCW-1:0]       pdec;
    logic [3:0]           bit_inc;
    logic [8:0]           ackw_inc;

    assign take  = q_valid && (!valid_reg || out_ready);
    assign q_pop = take;

    // truncate or widen the phase length, zero counts as one
    assign ticks_wide = {16'd0, cfg.phase_ticks};
    assign reload     = (ticks_wide[PCW-1:0] == '0) ? PCW'(1) : ticks_wide[PCW-1:0];
    assign pdec       = pcnt_reg - PCW'(pcnt_reg != '0);
    assign bit_inc    = bit_reg + 4'd1;
    assign ackw_inc   = {1'b0, ackw_reg} + 9'd1;

    always_comb
    begin
        cmd_next        = cmd_reg;
        shift_next      = shift_reg;
        bit_next        = bit_reg;
        step_next       = step_reg;
        pcnt_next       = pcnt_reg;
        ackw_next       = ackw_reg;
        ack_choice_next = ack_choice_reg;
        busy_next       = busy_reg;
        scl_next        = scl_reg;
        sda_next        = sda_reg;
        drive_next      = drive_reg;
        rx_next         = rx_reg;
        err_next        = err_reg;
        done_next       = 1'b0;

        if (!busy_reg)
        begin
            if (q_word.start)
            begin
                cmd_next  = q_word.op;
                busy_next = 1'b1;
                bit_next  = 4'd0;
                ackw_next = 8'd0;
                step_next = STEP_0;
                pcnt_next = reload;
                unique case (q_word.op)
                    OP_START:
                    begin
                        drive_next = 1'b1;
                        sda_next   = 1'b1;
                        scl_next   = 1'b1;
                    end
                    OP_STOP:
                    begin
                        drive_next = 1'b1;
                        scl_next   = 1'b0;
                        sda_next   = 1'b0;
                    end
                    OP_WRITE:
                    begin
                        sda_next   = q_word.tx_byte[DATA_BITS-1];
                        shift_next = {q_word.tx_byte[DATA_BITS-2:0], 1'b0};
                        drive_next = 1'b1;
                        scl_next   = 1'b0;
                    end
                    OP_READ:
                    begin
                        ack_choice_next = q_word.send_ack;
                        shift_next      = '0;
                        drive_next      = 1'b0;
                        sda_next        = 1'b1;
                        scl_next        = 1'b0;
                    end
                    default:
                    begin
                        drive_next = 1'b0;
                        sda_next   = 1'b1;
                    end
                endcase
            end
        end
        else if (cmd_reg == OP_WAIT && step_reg == STEP_POLL)
        begin
            if (!q_word.sda_in)
            begin
                scl_next  = 1'b0;
                err_next  = 1'b0;
                done_next = 1'b1;
            end
            else if (ackw_inc > {1'b0, cfg.ack_timeout})
            begin
                // timed out: flag and run a full stop condition
                err_next   = 1'b1;
                cmd_next   = OP_STOP;
                drive_next = 1'b1;
                scl_next   = 1'b0;
                sda_next   = 1'b0;
                step_next  = STEP_0;
                pcnt_next  = reload;
            end
            else
            begin
                ackw_next = ackw_inc[7:0];
            end
        end
        else
        begin
            pcnt_next = pdec;
            if (pdec == '0)
            begin
                unique case (cmd_reg)
                    OP_START:
                    begin
                        if (step_reg == STEP_0)
                        begin
                            sda_next  = 1'b0;
                            step_next = STEP_1;
                            pcnt_next = reload;
                        end
                        else
                        begin
                            scl_next  = 1'b0;
                            done_next = 1'b1;
                        end
                    end
                    OP_STOP:
                    begin
                        if (step_reg == STEP_0)
                        begin
                            sda_next  = 1'b1;
                            scl_next  = 1'b1;
                            step_next = STEP_1;
                            pcnt_next = reload;
                        end
                        else
                        begin
                            done_next = 1'b1;
                        end
                    end
                    OP_WRITE:
                    begin
                        if (step_reg == STEP_0)
                        begin
                            scl_next  = 1'b1;
                            step_next = STEP_1;
                            pcnt_next = reload;
                        end
                        else if (step_reg == STEP_1)
                        begin
                            scl_next  = 1'b0;
                            step_next = STEP_2;
                            pcnt_next = reload;
                        end
                        else
                        begin
                            bit_next = bit_inc;
                            if (bit_inc >= 4'(DATA_BITS))
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                sda_next   = shift_reg[DATA_BITS-1];
                                shift_next = {shift_reg[DATA_BITS-2:0], 1'b0};
                                drive_next = 1'b1;
                                scl_next   = 1'b0;
                                step_next  = STEP_0;
                                pcnt_next  = reload;
                            end
                        end
                    end
                    OP_READ:
                    begin
                        unique case (step_reg)
                            STEP_0:
                            begin
                                // sample on the tick SCL rises
                                scl_next   = 1'b1;
                                shift_next = {shift_reg[DATA_BITS-2:0], q_word.sda_in};
                                step_next  = STEP_1;
                                pcnt_next  = reload;
                            end
                            STEP_1:
                            begin
                                bit_next  = bit_inc;
                                scl_next  = 1'b0;
                                pcnt_next = reload;
                                if (bit_inc >= 4'(DATA_BITS))
                                begin
                                    rx_next    = shift_reg;
                                    drive_next = 1'b1;
                                    sda_next   = !ack_choice_reg;
                                    step_next  = STEP_2;
                                end
                                else
                                begin
                                    step_next = STEP_0;
                                end
                            end
                            STEP_2:
                            begin
                                scl_next  = 1'b1;
                                step_next = STEP_3;
                                pcnt_next = reload;
                            end
                            default:
                            begin
                                scl_next  = 1'b0;
                                done_next = 1'b1;
                            end
                        endcase
                    end
                    default:
                    begin
                        // wait for acknowledge: raise SCL, then poll
                        if (step_reg == STEP_0)
                        begin
                            scl_next  = 1'b1;
                            step_next = STEP_1;
                            pcnt_next = reload;
                        end
                        else
                        begin
                            step_next = STEP_POLL;
                            ackw_next = 8'd0;
                        end
                    end
                endcase
            end
        end

        if (done_next)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg        <= OP_START;
            shift_reg      <= '0;
            bit_reg        <= 4'd0;
            step_reg       <= STEP_0;
            pcnt_reg       <= '0;
            ackw_reg       <= 8'd0;
            ack_choice_reg <= 1'b0;
            busy_reg       <= 1'b0;
            scl_reg        <= 1'b1;
            sda_reg        <= 1'b1;
            drive_reg      <= 1'b1;
            rx_reg         <= '0;
            err_reg        <= 1'b0;
            done_reg       <= 1'b0;
            valid_reg      <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                cmd_reg        <= cmd_next;
                shift_reg      <= shift_next;
                bit_reg        <= bit_next;
                step_reg       <= step_next;
                pcnt_reg       <= pcnt_next;
                ackw_reg       <= ackw_next;
                ack_choice_reg <= ack_choice_next;
                busy_reg       <= busy_next;
                scl_reg        <= scl_next;
                sda_reg        <= sda_next;
                drive_reg      <= drive_next;
                rx_reg         <= rx_next;
                err_reg        <= err_next;
                done_reg       <= done_next;
                valid_reg      <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = valid_reg;
    assign scl_level   = scl_reg;
    assign sda_level   = sda_reg;
    assign sda_driving = drive_reg;
    assign busy_res    = busy_reg;
    assign done_res    = done_reg;
    assign rx_byte     = rx_reg;
    assign ack_missing = err_reg;

endmodule

`default_nettype wire

// File: rtl/i2c_master_bit_engine_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_unit: I2C master bit engine
// One tick word in, one line-state word out; sequences SCL/SDA phase by phase.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  s_*       in         s_tvalid / s_tready       tick word (tuser, tdata)
//  m_*       out        m_tvalid / m_tready       line-state word (tdata)
//  cfg_*     in         cfg_valid / cfg_ready     register index + data
//
//  One tick word per clock sustained while m_tready keeps up; each accepted
//  word passes through the intake queue, then the sequencer's result register,
//  which drives m_tdata. The sequencer state steps once per word, so the phase
//  update sets the rate. Reset leaves both lines high and driven, the engine idle.
//  A stalled m_tready holds the result; the two-entry queue keeps s_tready
//  high until it fills. cfg_ready is always high.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_unit
    import i2cbe_pkg::*;
#(
    parameter int PHASE_COUNT_WIDTH = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // [0] command_valid, [3:1] operation
    input  wire logic [3:0]            s_tuser,
    // [7:0] tx_byte, [8] send_ack, [9] sda_in, [15:10] zero
    input  wire logic [15:0]           s_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [0] scl_level, [1] sda_level, [2] sda_driving, [3] busy_res,
    // [4] done_res, [12:5] rx_byte, [13] ack_missing, [15:14] zero
    output logic [15:0]                m_tdata,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t        cfg_reg;
    tick_t       q_word;
    logic        q_valid;
    logic        q_pop;
    logic        scl_level, sda_level, sda_driving, busy_res, done_res, ack_missing;
    logic [7:0]  rx_byte;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.phase_ticks <= 16'd50;
            cfg_reg.ack_timeout <= 8'd250;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_PHASE_TICKS: cfg_reg.phase_ticks <= cfg_data;
                CFG_ACK_TIMEOUT: cfg_reg.ack_timeout <= cfg_data[7:0];
                default:         ;
            endcase
        end
    end

    i2cbe_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .command_valid (s_tuser[0]),
        .operation     (s_tuser[3:1]),
        .tx_byte       (s_tdata[7:0]),
        .send_ack      (s_tdata[8]),
        .sda_in        (s_tdata[9]),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .q_word        (q_word)
    );

    i2cbe_back #(
        .PHASE_COUNT_WIDTH (PHASE_COUNT_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_word      (q_word),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .scl_level   (scl_level),
        .sda_level   (sda_level),
        .sda_driving (sda_driving),
        .busy_res    (busy_res),
        .done_res    (done_res),
        .rx_byte     (rx_byte),
        .ack_missing (ack_missing)
    );

    assign m_tdata = {2'b00, ack_missing, rx_byte, done_res, busy_res,
                      sda_driving, sda_level, scl_level};

    // a completing command never reports itself busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && done_res) |-> !busy_res)
    else $error("done asserted while busy");

    // released SDA always reads high in the output latch
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !sda_driving) |-> sda_level)
    else $error("SDA released with low latch");

    // every accepted word is followed by a valid result on the output
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |-> ##2 m_tvalid)
    else $error("accepted word did not reach the output");

endmodule

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the I2C master bit engine
// Feeds timebase ticks carrying start, stop, write, read and wait-for-ack
// commands, predicts the SCL/SDA line state after every tick and checks each
// line-state word in order, with random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module tb;
    import i2cbe_pkg::*;

    // phase steps of the engine; a wait for acknowledge polls in step two
    localparam logic [2:0] PH_0    = 3'd0;
    localparam logic [2:0] PH_1    = 3'd1;
    localparam logic [2:0] PH_2    = 3'd2;
    localparam logic [2:0] PH_3    = 3'd3;
    localparam logic [2:0] PH_POLL = PH_2;
    localparam int unsigned NO_ANSWER = 32'hFFFF;

    typedef struct packed {
        logic       cmd;
        logic [2:0] op;
        logic [7:0] tx;
        logic       ack;
        logic       sda;
    } tick_s;

    typedef struct packed {
        logic [1:0] pad;
        logic       nack;
        logic [7:0] rx;
        logic       done;
        logic       busy;
        logic       drive;
        logic       sda;
        logic       scl;
    } line_word_t;

    // hold: issue only once the engine is idle, filling with plain ticks
    // answer: ticks of a wait before the slave pulls SDA low
    typedef struct {
        tick_s       item;
        bit          hold;
        int unsigned answer;
    } bus_order_s;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [3:0]            s_tuser = '0;
    logic [15:0]           s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [15:0]           m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // engine copy
    logic [15:0] phase_len = 16'd50;
    logic [7:0]  ack_limit = 8'd250;
    op_t         eng_op = OP_START;
    logic [7:0]  eng_shift = '0;
    logic [3:0]  eng_bits = '0;
    logic [2:0]  eng_step = PH_0;
    logic [15:0] eng_count = '0;
    logic [7:0]  poll_count = '0;
    logic        ack_sel = 1'b0;
    logic        eng_busy = 1'b0;
    logic        line_scl = 1'b1;
    logic        line_sda = 1'b1;
    logic        line_drive = 1'b1;
    logic [7:0]  rx_last = '0;
    logic        nack_flag = 1'b0;

    bus_order_s  bus_orders[$];
    line_word_t  expected_lines[$];
    tick_s       cur;
    logic        s_fire = 1'b0;
    logic        calm = 1'b0;
    logic        hold_off = 1'b0;
    bit          stall_go = 1'b0;
    int unsigned answer_left = 0;
    int unsigned ticks_sent = 0;
    int unsigned words_checked = 0;
    int unsigned completions = 0;
    int unsigned ack_timeouts = 0;
    int unsigned mismatches = 0;

    i2c_master_bit_engine_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function void enter_phase(input logic [2:0] step);
        eng_step = step;
        eng_count = (phase_len == 16'd0) ? 16'd1 : phase_len;
    endfunction

    function void shift_out_bit();
        line_sda = eng_shift[7];
        eng_shift = {eng_shift[6:0], 1'b0};
        line_drive = 1'b1;
        line_scl = 1'b0;
    endfunction

    // close the current line phase; returns 1 when the command is complete
    function bit finish_phase();
        case (eng_op)
            OP_START:
            begin
                if (eng_step == PH_0)
                begin
                    line_sda = 1'b0;
                    enter_phase(PH_1);
                    return 1'b0;
                end
                line_scl = 1'b0;
                return 1'b1;
            end
            OP_STOP:
            begin
                if (eng_step == PH_0)
                begin
                    line_sda = 1'b1;
                    line_scl = 1'b1;
                    enter_phase(PH_1);
                    return 1'b0;
                end
                return 1'b1;
            end
            OP_WRITE:
            begin
                if (eng_step == PH_0)
                begin
                    line_scl = 1'b1;
                    enter_phase(PH_1);
                    return 1'b0;
                end
                if (eng_step == PH_1)
                begin
                    line_scl = 1'b0;
                    enter_phase(PH_2);
                    return 1'b0;
                end
                eng_bits = eng_bits + 4'd1;
                if (eng_bits >= DATA_BITS)
                    return 1'b1;
                shift_out_bit();
                enter_phase(PH_0);
                return 1'b0;
            end
            OP_READ:
            begin
                if (eng_step == PH_0)
                begin
                    line_scl = 1'b1;
                    eng_shift = {eng_shift[6:0], 1'b0};
                    enter_phase(PH_1);
                    return 1'b0;
                end
                if (eng_step == PH_1)
                begin
                    eng_bits = eng_bits + 4'd1;
                    line_scl = 1'b0;
                    if (eng_bits >= DATA_BITS)
                    begin
                        rx_last = eng_shift;
                        line_drive = 1'b1;
                        line_sda = ~ack_sel;
                        enter_phase(PH_2);
                    end
                    else
                        enter_phase(PH_0);
                    return 1'b0;
                end
                if (eng_step == PH_2)
                begin
                    line_scl = 1'b1;
                    enter_phase(PH_3);
                    return 1'b0;
                end
                line_scl = 1'b0;
                return 1'b1;
            end
            default:
            begin
                if (eng_step == PH_0)
                begin
                    line_scl = 1'b1;
                    enter_phase(PH_1);
                    return 1'b0;
                end
                eng_step = PH_POLL;
                poll_count = '0;
                return 1'b0;
            end
        endcase
    endfunction

    // advance the engine copy by one tick and return the line state after it
    function line_word_t next_line_state(input tick_s t);
        logic       done;
        logic       sample;
        logic [8:0] nxt;
        line_word_t w;
        done = 1'b0;
        if (!eng_busy)
        begin
            if (t.cmd && t.op <= OP_WAIT)
            begin
                eng_op = op_t'(t.op);
                eng_busy = 1'b1;
                eng_bits = '0;
                poll_count = '0;
                case (eng_op)
                    OP_START:
                    begin
                        line_drive = 1'b1;
                        line_sda = 1'b1;
                        line_scl = 1'b1;
                    end
                    OP_STOP:
                    begin
                        line_drive = 1'b1;
                        line_scl = 1'b0;
                        line_sda = 1'b0;
                    end
                    OP_WRITE:
                    begin
                        eng_shift = t.tx;
                        shift_out_bit();
                    end
                    OP_READ:
                    begin
                        ack_sel = t.ack;
                        eng_shift = '0;
                        line_drive = 1'b0;
                        line_sda = 1'b1;
                        line_scl = 1'b0;
                    end
                    default:
                    begin
                        line_drive = 1'b0;
                        line_sda = 1'b1;
                    end
                endcase
                enter_phase(PH_0);
            end
        end
        else if (eng_op == OP_WAIT && eng_step == PH_POLL)
        begin
            if (!t.sda)
            begin
                line_scl = 1'b0;
                nack_flag = 1'b0;
                done = 1'b1;
            end
            else
            begin
                nxt = {1'b0, poll_count} + 9'd1;
                if (nxt > {1'b0, ack_limit})
                begin
                    // no answer in time: flag it and run a stop condition
                    nack_flag = 1'b1;
                    eng_op = OP_STOP;
                    line_drive = 1'b1;
                    line_scl = 1'b0;
                    line_sda = 1'b0;
                    enter_phase(PH_0);
                    ack_timeouts++;
                end
                else
                    poll_count = nxt[7:0];
            end
        end
        else
        begin
            if (eng_count != 16'd0)
                eng_count = eng_count - 16'd1;
            if (eng_count == 16'd0)
            begin
                sample = (eng_op == OP_READ && eng_step == PH_0);
                if (finish_phase())
                    done = 1'b1;
                if (sample)
                    eng_shift[0] = eng_shift[0] | t.sda;
            end
        end
        if (done)
        begin
            eng_busy = 1'b0;
            completions++;
        end
        w.pad = 2'b00;
        w.nack = nack_flag;
        w.rx = rx_last;
        w.done = done;
        w.busy = eng_busy;
        w.drive = line_drive;
        w.sda = line_sda;
        w.scl = line_scl;
        return w;
    endfunction

    function bus_order_s order_item(input bit hold, input logic cmd, input logic [2:0] op,
                                    input logic [7:0] tx, input logic ack,
                                    input int unsigned answer);
        bus_order_s o;
        o.item.cmd = cmd;
        o.item.op = op;
        o.item.tx = tx;
        o.item.ack = ack;
        o.item.sda = 1'($urandom_range(1));
        o.hold = hold;
        o.answer = answer;
        return o;
    endfunction

    // tick driver: predict each accepted word, then offer the next one
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (s_fire)
            begin
                expected_lines.push_back(next_line_state(cur));
                ticks_sent++;
            end
            if (!s_tvalid || s_fire)
            begin
                if (bus_orders.size() != 0 && (calm || $urandom_range(99) >= 17))
                begin
                    if (bus_orders[0].hold && eng_busy)
                    begin
                        // plain tick to move the busy engine along
                        cur.cmd = ($urandom_range(99) < 4);
                        cur.op = 3'($urandom_range(7));
                        cur.tx = 8'($urandom_range(255));
                        cur.ack = 1'($urandom_range(1));
                        if (eng_op == OP_WAIT)
                        begin
                            cur.sda = (answer_left != 0);
                            if (answer_left != 0)
                                answer_left--;
                        end
                        else
                            cur.sda = 1'($urandom_range(1));
                    end
                    else
                    begin
                        cur = bus_orders[0].item;
                        if (cur.cmd && cur.op == OP_WAIT)
                            answer_left = bus_orders[0].answer;
                        bus_orders.delete(0);
                    end
                    s_tvalid <= 1'b1;
                    s_tuser <= {cur.op, cur.cmd};
                    s_tdata <= {6'b0, cur.sda, cur.ack, cur.tx};
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        m_tready <= !hold_off && (calm || $urandom_range(99) >= 17);
    end

    // result monitor
    always @(posedge clk)
    begin
        line_word_t got;
        line_word_t exp_w;
        if (!rst_n)
            s_fire <= 1'b0;
        else
        begin
            s_fire <= s_tvalid && s_tready;
            if (m_tvalid && m_tready)
            begin
                got = line_word_t'(m_tdata);
                if (expected_lines.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected line word %h", m_tdata);
                end
                else
                begin
                    exp_w = expected_lines.pop_front();
                    if (got.scl !== exp_w.scl || got.sda !== exp_w.sda
                        || got.drive !== exp_w.drive || got.busy !== exp_w.busy
                        || got.done !== exp_w.done || got.rx !== exp_w.rx
                        || got.nack !== exp_w.nack || got.pad !== exp_w.pad)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"word %0d: expected scl %b sda %b drv %b busy %b done %b ",
                                      "rx %h nack %b pad %b, got scl %b sda %b drv %b busy %b ",
                                      "done %b rx %h nack %b pad %b"}, words_checked,
                                     exp_w.scl, exp_w.sda, exp_w.drive, exp_w.busy,
                                     exp_w.done, exp_w.rx, exp_w.nack, exp_w.pad,
                                     got.scl, got.sda, got.drive, got.busy,
                                     got.done, got.rx, got.nack, got.pad);
                    end
                    words_checked++;
                end
            end
        end
    end

    // long receiver hold-off so the intake fills and stalls the tick stream
    initial
    begin
        wait (stall_go);
        @(negedge clk);
        hold_off <= 1'b1;
        repeat (300) @(negedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

    task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_PHASE_TICKS)
            phase_len = val;
        else
            ack_limit = val[7:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // let the engine finish, then wait until every word has come back
    task automatic settle();
        bus_orders.push_back(order_item(1'b1, 1'b0, OP_START, 8'h00, 1'b0, 0));
        do
            @(posedge clk);
        while (bus_orders.size() != 0 || s_tvalid || expected_lines.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        int unsigned target;
        int unsigned k;
        int unsigned p;
        int unsigned answer;
        logic [2:0]  op;
        bit          hold;
        logic        cmd;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset register values: one start
        bus_orders.push_back(order_item(1'b1, 1'b1, OP_START, 8'h00, 1'b0, 0));
        settle();

        // shortest phase (zero taken as one), zero acknowledge timeout
        write_reg(CFG_PHASE_TICKS, 16'd0);
        write_reg(CFG_ACK_TIMEOUT, 16'd0);
        bus_orders.push_back(order_item(1'b1, 1'b1, OP_START, 8'h00, 1'b0, 0));
        bus_orders.push_back(order_item(1'b1, 1'b1, OP_WRITE, 8'h00, 1'b0, 0));
        bus_orders.push_back(order_item(1'b1, 1'b1, OP_WRITE, 8'hFF, 1'b1, 0));
        bus_orders.push_back(order_item(1'b1, 1'b1, OP_WRITE, 8'h80, 1'b0, 0));
        bus_orders.push_back(order_item(1'b1, 1'b1, OP_WAIT, 8'h00, 1'b0, 0));
        bus_orders.push_back(order_item(1'b1, 1'b1, OP_WAIT, 8'h00, 1'b0, NO_ANSWER));
        bus_orders.push_back(order_item(1'b1, 1'b1, OP_READ, 8'h00, 1'b1, 0));
        bus_orders.push_back(order_item(1'b1, 1'b1, OP_READ, 8'hFF, 1'b0, 0));
        bus_orders.push_back(order_item(1'b1, 1'b1, OP_STOP, 8'h00, 1'b0, 0));
        // wait straight after a stop keeps SCL high in its first phase
        bus_orders.push_back(order_item(1'b1, 1'b1, OP_WAIT, 8'h00, 1'b0, 0));
        for (int c = OP_WAIT + 1; c < 8; c++)
            bus_orders.push_back(order_item(1'b1, 1'b1, c[2:0], 8'hA5, 1'b1, 0));
        // second command lands while the start is still running
        bus_orders.push_back(order_item(1'b1, 1'b1, OP_START, 8'h00, 1'b0, 0));
        bus_orders.push_back(order_item(1'b0, 1'b1, OP_WRITE, 8'h5A, 1'b0, 0));
        bus_orders.push_back(order_item(1'b1, 1'b1, OP_WAIT, 8'h00, 1'b0, 1));
        bus_orders.push_back(order_item(1'b1, 1'b1, OP_STOP, 8'h00, 1'b0, 0));
        settle();

        // longest acknowledge timeout: answer on the last allowed tick, then one late
        write_reg(CFG_PHASE_TICKS, 16'd2);
        write_reg(CFG_ACK_TIMEOUT, 16'd255);
        bus_orders.push_back(order_item(1'b1, 1'b1, OP_WAIT, 8'h00, 1'b0, 2 * 2 + 255));
        bus_orders.push_back(order_item(1'b1, 1'b1, OP_WAIT, 8'h00, 1'b0, 2 * 2 + 256));
        settle();

        for (int r = 0; r < 5; r++)
        begin
            write_reg(CFG_PHASE_TICKS, (r == 0) ? 16'd0 : 16'($urandom_range(1, 4)));
            write_reg(CFG_ACK_TIMEOUT, 16'($urandom_range(0, 40)));
            calm = (r == 2);
            if (r == 1)
                stall_go = 1'b1;
            p = (phase_len == 16'd0) ? 1 : phase_len;
            target = ticks_sent + 50;
            while (ticks_sent < target)
            begin
                @(posedge clk);
                if (bus_orders.size() < 2)
                begin
                    k = $urandom_range(99);
                    hold = (k < 65 || (k >= 75 && k < 83));
                    cmd = (k < 83);
                    if (k >= 75 && k < 83)
                        op = 3'($urandom_range(OP_WAIT + 1, 7));
                    else
                        op = 3'($urandom_range(OP_WAIT));
                    if ($urandom_range(4) == 0)
                        answer = NO_ANSWER;
                    else
                        answer = $urandom_range(0, 2 * p + ack_limit + 3);
                    bus_orders.push_back(order_item(hold, cmd, op, 8'($urandom_range(255)),
                                                    1'($urandom_range(1)), answer));
                end
            end
            settle();
        end
        calm = 1'b0;

        $display("ran %0d ticks, %0d line words checked", ticks_sent, words_checked);
        $display("%0d commands completed, %0d acknowledge timeouts", completions, ack_timeouts);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: sim.f
rtl/i2cbe_pkg.sv
rtl/i2cbe_front.sv
rtl/i2cbe_back.sv
rtl/i2c_master_bit_engine_unit.sv
tb/tb.sv
